// ----- rtl/hca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hca_pkg
// Fixed-point constants, stage types and helper functions shared by the
// HLS color adjust pipeline.
// ----------------------------------------------------------------------------
package hca_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int HUE_FRAC_BITS = 6;

  // fraction 0..ONE needs one bit above the fraction bits
  localparam int FW  = FRAC_BITS + 1;
  localparam int ONE = 1 << FRAC_BITS;

  localparam int DEG60  = 60 << HUE_FRAC_BITS;
  localparam int DEG120 = 2 * DEG60;
  localparam int DEG180 = 3 * DEG60;
  localparam int DEG240 = 4 * DEG60;
  localparam int DEG360 = 6 * DEG60;
  localparam int HW     = $clog2(DEG360);
  localparam int H60W   = $clog2(DEG60 + 1);

  // divider: one quotient bit per stage
  localparam int DIV_STEPS = (FW > H60W) ? FW : H60W;
  localparam int DVW       = FW + ((FRAC_BITS > H60W) ? FRAC_BITS : H60W);

  // register widths
  localparam int CFG_IW   = 8;
  localparam int CFG_DW   = 16;
  localparam int HUE_OFFW = 16;
  localparam int OFFW     = 14;

  // signed working width for clamps and ramp values
  localparam int CW = ((FW + 3) > (OFFW + 1)) ? (FW + 3) : (OFFW + 1);

  // hue modulo: bias makes the sum positive, then binary remainder steps
  localparam int HUE_BIAS   = DEG360 * ((1 << (HUE_OFFW - 1)) / DEG360 + 1);
  localparam int HUE_UMAX   = DEG360 - 1 + (1 << (HUE_OFFW - 1)) - 1 + HUE_BIAS;
  localparam int HMOD_STEPS = $clog2(HUE_UMAX / DEG360 + 1);
  localparam int UW         = $clog2(HUE_UMAX + 1);

  // reciprocal of 255, exact floor for dividends below 2**24 (k = 32)
  localparam int XW = 8 + FRAC_BITS;
  localparam logic [24:0] RECIP255 = 25'd16843010;

  // reciprocal of 60, exact floor for dividends below 2**26 (k = 32)
  localparam int PW  = FW + 1 + H60W;
  localparam int XW2 = PW - HUE_FRAC_BITS;
  localparam int QW  = XW2 + 27;
  localparam logic [26:0] RECIP60 = 27'd71582789;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_HUE   = 8'd0;
  localparam logic [CFG_IW-1:0] REG_LIGHT = 8'd1;
  localparam logic [CFG_IW-1:0] REG_SAT   = 8'd2;
  localparam logic [CFG_IW-1:0] REG_ALPHA = 8'd3;

  // hue sector of the max channel
  localparam logic [1:0] SEC_R = 2'd0;
  localparam logic [1:0] SEC_G = 2'd1;
  localparam logic [1:0] SEC_B = 2'd2;

  // ramp segment of one output channel
  localparam logic [1:0] SEG_LOW  = 2'd0;
  localparam logic [1:0] SEG_RAMP = 2'd1;
  localparam logic [1:0] SEG_HIGH = 2'd2;

  typedef struct packed {
    logic [FW-1:0]        rem;
    logic [DIV_STEPS-1:0] low;
    logic [DIV_STEPS-1:0] quo;
    logic [FW-1:0]        dvs;
  } div_t;

  typedef struct packed {
    logic       eob;
    logic [7:0] achan;
  } tail_t;

  typedef struct packed {
    logic          gray;
    logic          neg;
    logic [1:0]    sec;
    logic [FW-1:0] l;
    tail_t         tail;
  } side_t;

  // ceil(c * ONE / 255)
  function automatic logic [FW-1:0] to_frac(input logic [7:0] c);
    logic [XW-1:0]    x;
    logic [XW+24:0]   p;
    x = {c, {FRAC_BITS{1'b0}}} + XW'(254);
    p = (XW + 25)'(x) * (XW + 25)'(RECIP255);
    return p[32 +: FW];
  endfunction

  function automatic logic [FW-1:0] clamp_frac(input logic signed [CW-1:0] v);
    logic [FW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(CW'(ONE))) begin
      res = FW'(ONE);
    end else begin
      res = v[FW-1:0];
    end
    return res;
  endfunction

  // (f * 255) >> FRAC_BITS for f in 0..ONE
  function automatic logic [7:0] to_chan(input logic [FW-1:0] f);
    logic [FW+7:0] p;
    p = {f, 8'b0} - (FW + 8)'(f);
    return p[FRAC_BITS +: 8];
  endfunction

  // one restoring division step
  function automatic div_t div_step(input div_t x);
    logic [FW:0] t;
    logic        qb;
    div_t        y;
    t  = {x.rem, x.low[DIV_STEPS-1]};
    qb = 1'b0;
    if (t >= {1'b0, x.dvs}) begin
      t  = t - {1'b0, x.dvs};
      qb = 1'b1;
    end
    y     = x;
    y.rem = t[FW-1:0];
    y.low = x.low << 1;
    y.quo = {x.quo[DIV_STEPS-2:0], qb};
    return y;
  endfunction

endpackage

// ----- rtl/hls_color_adjust.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hls_color_adjust
// Pipelined RGBA8 hue / lightness / saturation / alpha adjust.
// ----------------------------------------------------------------------------
// usage
//   input beat: pixel on in_pixel_in (R 7:0, G 15:8, B 23:16, A 31:24) and
//   in_end_of_block, taken at a rising edge with start high and busy low.
//   busy is always low: a new pixel may enter every cycle.
//   result beat: out_valid is high for one cycle with out_pixel_out and
//   out_end_of_block_out; the receiver must take it in that cycle.
//   structure: each result passes the two restoring dividers (saturation and
//   hue), one quotient bit a stage, plus ten stages of conversion and ramp
//   arithmetic, and leaves from the registered stage 10 outputs.
//   throughput: one pixel per clock, results in input order.
//   config: cfg_valid/cfg_ready write channel, cfg_ready always high;
//   index 0 hue, 1 lightness, 2 saturation, 3 alpha; other indexes ignored.
//   write registers only while the pipeline is empty.
//   reset: synchronous active-low rst_n clears all valid bits and the
//   offsets; beats in flight are dropped.
// ----------------------------------------------------------------------------
module hls_color_adjust
  import hca_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       in_pixel_in,
  input  logic              in_end_of_block,
  output logic              out_valid,
  output logic [31:0]       out_pixel_out,
  output logic              out_end_of_block_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int OUT_DLY = 10 + DIV_STEPS;

  // configuration registers
  logic signed [HUE_OFFW-1:0] hue_off_r;
  logic signed [OFFW-1:0]     light_off_r;
  logic signed [OFFW-1:0]     sat_off_r;
  logic signed [OFFW-1:0]     alpha_off_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_off_r   <= '0;
      light_off_r <= '0;
      sat_off_r   <= '0;
      alpha_off_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HUE:   hue_off_r   <= cfg_data[HUE_OFFW-1:0];
        REG_LIGHT: light_off_r <= cfg_data[OFFW-1:0];
        REG_SAT:   sat_off_r   <= cfg_data[OFFW-1:0];
        REG_ALPHA: alpha_off_r <= cfg_data[OFFW-1:0];
        default: begin
        end
      endcase
    end
  end

  // valid bits
  logic v0_r, v1_r, v2_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic dv_v_r [0:DIV_STEPS];

  // stage 0: input register
  logic [31:0] pix0_r;
  logic        eob0_r;

  // stage 1: channel fractions
  logic [FW-1:0] r1_r, g1_r, b1_r, a1_r;
  logic          eob1_r;

  // stage 2: max / min, sector, alpha clamp
  logic [FW-1:0]        mx_c, mn_c;
  logic [FW:0]          sum_c;
  logic [1:0]           sec_nxt;
  logic signed [FW:0]   diff_nxt;
  logic [FW-1:0]        denom_nxt;
  logic [FW-1:0]        al_nxt;
  logic [FW-1:0]        delta2_r, denom2_r, l2_r, al2_r;
  logic signed [FW:0]   diff2_r;
  logic [1:0]           sec2_r;
  logic                 eob2_r;

  // stage 3 and divider stages
  logic [FW-1:0]  mag_c;
  logic [DVW-1:0] hnum_c, snum_c;
  div_t  dvs_nxt [0:DIV_STEPS];
  div_t  dvh_nxt [0:DIV_STEPS];
  side_t sd_nxt;
  div_t  dvs_r   [0:DIV_STEPS];
  div_t  dvh_r   [0:DIV_STEPS];
  side_t sd_r    [0:DIV_STEPS];

  // stage 4: hue sum, lightness and saturation clamps
  logic [HW-1:0]        base_c;
  logic signed [HW+1:0] hs_c;
  logic signed [UW:0]   tsum_c;
  logic [FW-1:0]        sraw_c;
  logic [UW-1:0]        u4_r;
  logic [FW-1:0]        l4_r, s4_r;
  tail_t                tl4_r;

  // stage 5: hue modulo
  logic [UW:0]   um_c;
  logic [HW-1:0] h5_r;
  logic [FW-1:0] l5_r, s5_r;
  tail_t         tl5_r;

  // stage 6: channel hues, segments, l*s
  logic [2:0][HW-1:0]   hh_c;
  logic [2:0][1:0]      seg_nxt;
  logic [2:0][H60W-1:0] t_nxt;
  logic [2:0][1:0]      seg6_r;
  logic [2:0][H60W-1:0] t6_r;
  logic [2*FW-1:0]      ls6_r;
  logic [FW-1:0]        l6_r, s6_r;
  tail_t                tl6_r;

  // stage 7: m1 / m2
  logic [FW-1:0]        ls_c;
  logic [FW:0]          two_l_c, m2_c;
  logic signed [FW+1:0] m1_c;
  logic [FW:0]          d_c;
  logic signed [FW+1:0] m1_7_r;
  logic [FW:0]          m2_7_r, d7_r;
  logic [2:0][1:0]      seg7_r;
  logic [2:0][H60W-1:0] t7_r;
  logic [FW-1:0]        l7_r;
  logic                 sz7_r;
  tail_t                tl7_r;

  // stage 8: ramp products
  logic [2:0][PW-1:0]   prod8_r;
  logic signed [FW+1:0] m1_8_r;
  logic [FW:0]          m2_8_r;
  logic [2:0][1:0]      seg8_r;
  logic [FW-1:0]        l8_r;
  logic                 sz8_r;
  tail_t                tl8_r;

  // stage 9: division by 60 degrees via reciprocal
  logic [2:0][QW-1:0]   q9_r;
  logic signed [FW+1:0] m1_9_r;
  logic [FW:0]          m2_9_r;
  logic [2:0][1:0]      seg9_r;
  logic [FW-1:0]        l9_r;
  logic                 sz9_r;
  tail_t                tl9_r;

  // stage 10: output register
  logic signed [CW-1:0] val_c [3];
  logic [2:0][7:0]      ch_nxt;
  logic [31:0]          px10_r;
  logic                 eob10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else begin
      v0_r      <= start && !busy;
      v1_r      <= v0_r;
      v2_r      <= v1_r;
      dv_v_r[0] <= v2_r;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
      v4_r  <= dv_v_r[DIV_STEPS];
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  // stage 2 logic
  always_comb begin
    mx_c = (r1_r > g1_r) ? ((r1_r > b1_r) ? r1_r : b1_r) : ((g1_r > b1_r) ? g1_r : b1_r);
    mn_c = (r1_r < g1_r) ? ((r1_r < b1_r) ? r1_r : b1_r) : ((g1_r < b1_r) ? g1_r : b1_r);
    sum_c = {1'b0, mx_c} + {1'b0, mn_c};
    denom_nxt = (sum_c <= (FW + 1)'(ONE)) ? sum_c[FW-1:0]
                                          : FW'((FW + 1)'(2 * ONE) - sum_c);
    // red wins ties, then green
    priority if (r1_r == mx_c) begin
      sec_nxt  = SEC_R;
      diff_nxt = $signed({1'b0, g1_r}) - $signed({1'b0, b1_r});
    end else if (g1_r == mx_c) begin
      sec_nxt  = SEC_G;
      diff_nxt = $signed({1'b0, b1_r}) - $signed({1'b0, r1_r});
    end else begin
      sec_nxt  = SEC_B;
      diff_nxt = $signed({1'b0, r1_r}) - $signed({1'b0, g1_r});
    end
    al_nxt = clamp_frac(CW'($signed({1'b0, a1_r})) + CW'(alpha_off_r));
  end

  // stage 3: divider operands
  always_comb begin
    mag_c  = diff2_r[FW] ? FW'(-diff2_r) : FW'(diff2_r);
    hnum_c = DVW'(mag_c) * DVW'(DEG60);
    snum_c = DVW'(delta2_r) << FRAC_BITS;

    dvs_nxt[0].rem = FW'(snum_c >> DIV_STEPS);
    dvs_nxt[0].low = snum_c[DIV_STEPS-1:0];
    dvs_nxt[0].quo = '0;
    dvs_nxt[0].dvs = denom2_r;
    dvh_nxt[0].rem = FW'(hnum_c >> DIV_STEPS);
    dvh_nxt[0].low = hnum_c[DIV_STEPS-1:0];
    dvh_nxt[0].quo = '0;
    dvh_nxt[0].dvs = delta2_r;

    sd_nxt.gray       = (delta2_r == '0);
    sd_nxt.neg        = diff2_r[FW];
    sd_nxt.sec        = sec2_r;
    sd_nxt.l          = l2_r;
    sd_nxt.tail.eob   = eob2_r;
    sd_nxt.tail.achan = to_chan(al2_r);

    for (int k = 1; k <= DIV_STEPS; k++) begin
      dvs_nxt[k] = div_step(dvs_r[k-1]);
      dvh_nxt[k] = div_step(dvh_r[k-1]);
    end
  end

  // stage 4 logic
  always_comb begin
    unique case (sd_r[DIV_STEPS].sec)
      SEC_R:   base_c = '0;
      SEC_G:   base_c = HW'(DEG120);
      SEC_B:   base_c = HW'(DEG240);
      default: base_c = '0;
    endcase
  end

  always_comb begin
    hs_c = $signed((HW + 2)'(base_c));
    if (sd_r[DIV_STEPS].neg) begin
      hs_c = hs_c - $signed((HW + 2)'(dvh_r[DIV_STEPS].quo));
    end else begin
      hs_c = hs_c + $signed((HW + 2)'(dvh_r[DIV_STEPS].quo));
    end
    if (hs_c < 0) begin
      hs_c = hs_c + $signed((HW + 2)'(DEG360));
    end
    // gray pixels take hue zero
    if (sd_r[DIV_STEPS].gray) begin
      hs_c = '0;
    end
    tsum_c = (UW + 1)'(hs_c) + (UW + 1)'(hue_off_r) + $signed((UW + 1)'(HUE_BIAS));
    sraw_c = sd_r[DIV_STEPS].gray ? '0 : FW'(dvs_r[DIV_STEPS].quo);
  end

  // stage 5: remainder by shifted multiples of 360 degrees
  always_comb begin
    um_c = {1'b0, u4_r};
    for (int k = HMOD_STEPS - 1; k >= 0; k--) begin
      if (um_c >= (UW + 1)'(DEG360 << k)) begin
        um_c = um_c - (UW + 1)'(DEG360 << k);
      end
    end
  end

  // stage 6: per-channel hue and ramp segment
  always_comb begin
    hh_c[0] = (h5_r < HW'(DEG240)) ? h5_r + HW'(DEG120) : h5_r - HW'(DEG240);
    hh_c[1] = h5_r;
    hh_c[2] = (h5_r >= HW'(DEG120)) ? h5_r - HW'(DEG120) : h5_r + HW'(DEG240);
    for (int c = 0; c < 3; c++) begin
      priority if (hh_c[c] < HW'(DEG60)) begin
        seg_nxt[c] = SEG_RAMP;
        t_nxt[c]   = H60W'(hh_c[c]);
      end else if (hh_c[c] < HW'(DEG180)) begin
        seg_nxt[c] = SEG_HIGH;
        t_nxt[c]   = '0;
      end else if (hh_c[c] < HW'(DEG240)) begin
        seg_nxt[c] = SEG_RAMP;
        t_nxt[c]   = H60W'(HW'(DEG240) - hh_c[c]);
      end else begin
        seg_nxt[c] = SEG_LOW;
        t_nxt[c]   = '0;
      end
    end
  end

  // stage 7: m1 / m2
  always_comb begin
    ls_c    = FW'(ls6_r >> FRAC_BITS);
    two_l_c = {l6_r, 1'b0};
    if (two_l_c <= (FW + 1)'(ONE)) begin
      m2_c = (FW + 1)'(l6_r) + (FW + 1)'(ls_c);
    end else begin
      m2_c = (FW + 1)'(l6_r) + (FW + 1)'(s6_r) - (FW + 1)'(ls_c);
    end
    m1_c = $signed({1'b0, two_l_c}) - $signed({1'b0, m2_c});
    d_c  = (FW + 1)'({m2_c, 1'b0} - {1'b0, two_l_c});
  end

  // stage 10: ramp value, clamp, back to 8 bits
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unique case (seg9_r[c])
        SEG_RAMP: val_c[c] = CW'(m1_9_r) + $signed(CW'(q9_r[c][32 +: FW+1]));
        SEG_HIGH: val_c[c] = $signed(CW'(m2_9_r));
        SEG_LOW:  val_c[c] = CW'(m1_9_r);
        default:  val_c[c] = CW'(m1_9_r);
      endcase
      // zero saturation gives lightness on all three channels
      if (sz9_r) begin
        val_c[c] = $signed(CW'(l9_r));
      end
      ch_nxt[c] = to_chan(clamp_frac(val_c[c]));
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pix0_r <= in_pixel_in;
    eob0_r <= in_end_of_block;

    r1_r   <= to_frac(pix0_r[7:0]);
    g1_r   <= to_frac(pix0_r[15:8]);
    b1_r   <= to_frac(pix0_r[23:16]);
    a1_r   <= to_frac(pix0_r[31:24]);
    eob1_r <= eob0_r;

    delta2_r <= mx_c - mn_c;
    denom2_r <= denom_nxt;
    l2_r     <= sum_c[FW:1];
    al2_r    <= al_nxt;
    diff2_r  <= diff_nxt;
    sec2_r   <= sec_nxt;
    eob2_r   <= eob1_r;

    for (int k = 0; k <= DIV_STEPS; k++) begin
      dvs_r[k] <= dvs_nxt[k];
      dvh_r[k] <= dvh_nxt[k];
    end
    sd_r[0] <= sd_nxt;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      sd_r[k] <= sd_r[k-1];
    end

    u4_r  <= tsum_c[UW-1:0];
    l4_r  <= clamp_frac(CW'($signed({1'b0, sd_r[DIV_STEPS].l})) + CW'(light_off_r));
    s4_r  <= clamp_frac(CW'($signed({1'b0, sraw_c})) - CW'(sat_off_r));
    tl4_r <= sd_r[DIV_STEPS].tail;

    h5_r  <= HW'(um_c);
    l5_r  <= l4_r;
    s5_r  <= s4_r;
    tl5_r <= tl4_r;

    seg6_r <= seg_nxt;
    t6_r   <= t_nxt;
    ls6_r  <= (2 * FW)'(l5_r) * (2 * FW)'(s5_r);
    l6_r   <= l5_r;
    s6_r   <= s5_r;
    tl6_r  <= tl5_r;

    m1_7_r <= m1_c;
    m2_7_r <= m2_c;
    d7_r   <= d_c;
    seg7_r <= seg6_r;
    t7_r   <= t6_r;
    l7_r   <= l6_r;
    sz7_r  <= (s6_r == '0);
    tl7_r  <= tl6_r;

    for (int c = 0; c < 3; c++) begin
      prod8_r[c] <= PW'(d7_r) * PW'(t7_r[c]);
    end
    m1_8_r <= m1_7_r;
    m2_8_r <= m2_7_r;
    seg8_r <= seg7_r;
    l8_r   <= l7_r;
    sz8_r  <= sz7_r;
    tl8_r  <= tl7_r;

    for (int c = 0; c < 3; c++) begin
      q9_r[c] <= QW'(prod8_r[c] >> HUE_FRAC_BITS) * QW'(RECIP60);
    end
    m1_9_r <= m1_8_r;
    m2_9_r <= m2_8_r;
    seg9_r <= seg8_r;
    l9_r   <= l8_r;
    sz9_r  <= sz8_r;
    tl9_r  <= tl8_r;

    px10_r  <= {tl9_r.achan, ch_nxt[2], ch_nxt[1], ch_nxt[0]};
    eob10_r <= tl9_r.eob;
  end

  assign out_valid            = v10_r;
  assign out_pixel_out        = px10_r;
  assign out_end_of_block_out = eob10_r;

  // saturation quotient never exceeds one
  assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[DIV_STEPS] && !sd_r[DIV_STEPS].gray)
      |-> (dvs_r[DIV_STEPS].quo <= DIV_STEPS'(ONE)))
    else $error("saturation quotient above one");

  // hue quotient stays within one sector
  assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[DIV_STEPS] && !sd_r[DIV_STEPS].gray)
      |-> (dvh_r[DIV_STEPS].quo <= DIV_STEPS'(DEG60)))
    else $error("hue quotient above 60 degrees");

  // hue after the modulo lies in one turn
  assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (h5_r < HW'(DEG360)))
    else $error("hue not reduced below 360 degrees");

  // every accepted beat comes out after the fixed latency
  assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> ##OUT_DLY out_valid)
    else $error("result strobe missing");

  // the end marker travels with its pixel
  assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> ##OUT_DLY (out_end_of_block_out == $past(eob0_r, OUT_DLY)))
    else $error("end marker out of step");

endmodule
